@@ rtl/core/fcs_pkg.sv @@
// Shared types and constants for the flow shop completion time block.
package fcs_pkg;

	localparam int unsigned MAX_MACHINES = 16;
	localparam int unsigned MAX_FAMILIES = 16;
	localparam int unsigned MACH_W       = $clog2(MAX_MACHINES);
	localparam int unsigned FAM_W        = $clog2(MAX_FAMILIES);
	localparam int unsigned PTIME_W      = 16;
	localparam int unsigned TIME_W       = 32;
	localparam int unsigned NM_W         = 5;
	localparam int unsigned TAB_AW       = MACH_W + 2 * FAM_W;

	localparam logic [NM_W-1:0] NM_MAX   = NM_W'(MAX_MACHINES);
	localparam logic [NM_W-1:0] NM_RESET = NM_W'(MAX_MACHINES);

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_OP    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		SETUP_FIRST,
		SETUP_CHANGE,
		SETUP_NONE
	} setup_kind_t;

	typedef struct packed {
		logic               op;
		logic               clr;
		logic [MACH_W-1:0]  machine;
		logic               last;
		setup_kind_t        kind;
		logic [PTIME_W-1:0] ptime;
	} issue_t;

	typedef struct packed {
		logic [TIME_W-1:0] done;
		logic [MACH_W-1:0] machine;
		logic              last;
	} result_t;

endpackage

@@ rtl/core/fcs_setup_table.sv @@
// Setup time table: single-port synchronous memory with a registered read port.
module fcs_setup_table (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic                         rd_en,
	input  logic [fcs_pkg::TAB_AW-1:0]   addr,
	input  logic [fcs_pkg::PTIME_W-1:0]  wdata,
	output logic [fcs_pkg::PTIME_W-1:0]  rdata
);

	localparam int unsigned DEPTH = 2 ** fcs_pkg::TAB_AW;

	logic [fcs_pkg::PTIME_W-1:0] mem_q [DEPTH];
	logic [fcs_pkg::PTIME_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/fcs_family_track.sv @@
// Per-machine last family tracking and setup kind decode.
module fcs_family_track (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en_op,
	input  logic                        en_clr,
	input  logic [fcs_pkg::MACH_W-1:0]  machine,
	input  logic [fcs_pkg::FAM_W-1:0]   family,
	output fcs_pkg::setup_kind_t        kind,
	output logic [fcs_pkg::FAM_W-1:0]   from_family
);

	logic [fcs_pkg::FAM_W-1:0]  last_fam_q [fcs_pkg::MAX_MACHINES];
	logic [fcs_pkg::MAX_MACHINES-1:0] vld_q;
	logic                       vld;
	logic [fcs_pkg::FAM_W-1:0]  last_fam;

	always_comb begin
		vld         = vld_q[machine];
		last_fam    = last_fam_q[machine];
		from_family = vld ? last_fam : family;
		if (!vld) begin
			kind = fcs_pkg::SETUP_FIRST;
		end else if (last_fam != family) begin
			kind = fcs_pkg::SETUP_CHANGE;
		end else begin
			kind = fcs_pkg::SETUP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en_clr) begin
			vld_q <= '0;
		end else if (en_op) begin
			vld_q[machine] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_op) begin
			last_fam_q[machine] <= family;
		end
	end

endmodule

@@ rtl/core/fcs_timing.sv @@
// Ready time memory and two-stage completion time pipeline with forwarding.
module fcs_timing (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  fcs_pkg::issue_t              issue,
	input  logic [fcs_pkg::PTIME_W-1:0]  setup,
	output logic                         s2_op,
	output fcs_pkg::result_t             res
);

	localparam int unsigned TW = fcs_pkg::TIME_W;
	localparam int unsigned PW = fcs_pkg::PTIME_W;

	logic [TW-1:0] ready_mem_q [fcs_pkg::MAX_MACHINES];
	logic [TW-1:0] ready_rd_q;
	logic [TW-1:0] prev_q;

	fcs_pkg::issue_t iss_s1;
	logic            fwd_s1;
	logic            col_s1;

	logic                       op_s2;
	logic                       clr_s2;
	logic [fcs_pkg::MACH_W-1:0] machine_s2;
	logic                       last_s2;
	logic                       fwd_s2;
	logic [TW-1:0]              r_s2;
	logic [PW-1:0]              ptime_s2;
	logic [PW:0]                st_s2;

	logic [TW-1:0] base1;
	logic [TW:0]   sum1;
	logic [TW-1:0] r1;
	logic [PW:0]   st1;
	logic          fwd_new;
	logic          col_new;

	logic [TW:0]   fsum;
	logic [TW-1:0] pred;
	logic [TW-1:0] mx;
	logic [TW:0]   nsum;
	logic [TW-1:0] done;

	assign fwd_new = issue.op && iss_s1.op && (iss_s1.machine == issue.machine);
	assign col_new = issue.op && op_s2 && (machine_s2 == issue.machine);

	always_comb begin
		base1 = col_s1 ? prev_q : ready_rd_q;
		sum1  = {1'b0, base1} + (TW+1)'(setup);
		unique case (iss_s1.kind)
			fcs_pkg::SETUP_FIRST: begin
				r1  = TW'(setup);
				st1 = (PW+1)'(iss_s1.ptime);
			end
			fcs_pkg::SETUP_CHANGE: begin
				r1  = sum1[TW] ? {TW{1'b1}} : sum1[TW-1:0];
				st1 = (PW+1)'(setup) + (PW+1)'(iss_s1.ptime);
			end
			fcs_pkg::SETUP_NONE: begin
				r1  = base1;
				st1 = (PW+1)'(iss_s1.ptime);
			end
			default: begin
				r1  = base1;
				st1 = (PW+1)'(iss_s1.ptime);
			end
		endcase
	end

	always_comb begin
		fsum = {1'b0, prev_q} + (TW+1)'(st_s2);
		pred = (machine_s2 == '0) ? '0 : prev_q;
		mx   = (r_s2 > pred) ? r_s2 : pred;
		nsum = {1'b0, mx} + (TW+1)'(ptime_s2);
		if (fwd_s2) begin
			done = fsum[TW] ? {TW{1'b1}} : fsum[TW-1:0];
		end else begin
			done = nsum[TW] ? {TW{1'b1}} : nsum[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
			fwd_s1 <= 1'b0;
			col_s1 <= 1'b0;
			op_s2  <= 1'b0;
			clr_s2 <= 1'b0;
			fwd_s2 <= 1'b0;
			prev_q <= '0;
		end else if (adv) begin
			iss_s1 <= issue;
			fwd_s1 <= fwd_new;
			col_s1 <= col_new;
			op_s2  <= iss_s1.op;
			clr_s2 <= iss_s1.clr;
			fwd_s2 <= fwd_s1;
			if (clr_s2) begin
				prev_q <= '0;
			end else if (op_s2) begin
				prev_q <= done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			machine_s2 <= iss_s1.machine;
			last_s2    <= iss_s1.last;
			r_s2       <= r1;
			ptime_s2   <= iss_s1.ptime;
			st_s2      <= st1;
			ready_rd_q <= ready_mem_q[issue.machine];
			if (op_s2) begin
				ready_mem_q[machine_s2] <= done;
			end
		end
	end

	assign s2_op       = op_s2;
	assign res.done    = done;
	assign res.machine = machine_s2;
	assign res.last    = last_s2;

endmodule

@@ rtl/core/flowshop_family_completion_times.sv @@
// Top level: flow shop completion times with family setups.
// Input stream (s_*): one transaction per command. s_tuser carries the command:
// write a setup entry, clear the sequence, or process one operation. Operations
// arrive job by job, machine by machine, with the job's family and its
// processing time.
// Output stream (m_*): one transaction per processed operation on a machine in
// use, with its completion time and machine; m_tlast marks the last machine in
// use, where the completion time is the current makespan. Setup writes, clears,
// operations on unused machines and unknown commands give no output.
// Configuration: APB register at address 0 holds the machine count in use.
// Path: an operation passes stage 1, stage 2 and the output register before its result is valid.
// Throughput: one transaction per cycle while no stall holds the input; the completion time recurrence closes
// in the second pipeline stage, with the ready time memory forwarded from it.
// Reset: family history and the previous completion time clear, the ready time memory
// is not reset, machine count is 16, the setup table holds no defined value until written.
// Stall: the output register holds a result while m_tready is low; the input
// keeps taking transactions until a result in the last stage waits behind it.
module flowshop_family_completion_times (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // machine[3:0], from_family[7:4], family[11:8], time_value[27:12]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // completion_time[31:0], done_machine[35:32]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_NUM_MACHINES = 1'b0;

	logic [fcs_pkg::NM_W-1:0]    nm_q;
	logic [fcs_pkg::NM_W-1:0]    nm_eff;
	logic                        adv;
	logic                        acc;
	fcs_pkg::cmd_t               cmd;
	logic [fcs_pkg::MACH_W-1:0]  machine;
	logic [fcs_pkg::FAM_W-1:0]   from_in;
	logic [fcs_pkg::FAM_W-1:0]   family;
	logic [fcs_pkg::PTIME_W-1:0] ptime;
	logic                        in_range;
	logic                        op_acc;
	logic                        clr_acc;
	logic                        wr_acc;
	fcs_pkg::setup_kind_t        kind;
	logic [fcs_pkg::FAM_W-1:0]   from_trk;
	logic [fcs_pkg::TAB_AW-1:0]  tab_addr;
	logic [fcs_pkg::PTIME_W-1:0] setup;
	fcs_pkg::issue_t             issue;
	logic                        s2_op;
	fcs_pkg::result_t            res;
	logic                        out_vld_q;
	fcs_pkg::result_t            out_q;

	assign cmd     = fcs_pkg::cmd_t'(s_tuser);
	assign machine = s_tdata[3:0];
	assign from_in = s_tdata[7:4];
	assign family  = s_tdata[11:8];
	assign ptime   = s_tdata[27:12];

	always_comb begin
		priority if (nm_q == '0) begin
			nm_eff = fcs_pkg::NM_W'(1);
		end else if (nm_q > fcs_pkg::NM_MAX) begin
			nm_eff = fcs_pkg::NM_MAX;
		end else begin
			nm_eff = nm_q;
		end
	end

	assign adv      = !(out_vld_q && !m_tready && s2_op);
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;
	assign in_range = fcs_pkg::NM_W'(machine) < nm_eff;

	always_comb begin
		op_acc  = 1'b0;
		clr_acc = 1'b0;
		wr_acc  = 1'b0;
		unique case (cmd)
			fcs_pkg::CMD_WRITE: wr_acc  = acc;
			fcs_pkg::CMD_CLEAR: clr_acc = acc;
			fcs_pkg::CMD_OP:    op_acc  = acc && in_range;
			default: begin
			end
		endcase
	end

	assign tab_addr = wr_acc ? {machine, from_in, family} : {machine, from_trk, family};

	assign issue.op      = op_acc;
	assign issue.clr     = clr_acc;
	assign issue.machine = machine;
	assign issue.last    = fcs_pkg::NM_W'(machine) == (nm_eff - fcs_pkg::NM_W'(1));
	assign issue.kind    = kind;
	assign issue.ptime   = ptime;

	fcs_family_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.en_op       (op_acc),
		.en_clr      (clr_acc),
		.machine     (machine),
		.family      (family),
		.kind        (kind),
		.from_family (from_trk)
	);

	fcs_setup_table u_table (
		.clk   (clk),
		.wr_en (wr_acc),
		.rd_en (adv),
		.addr  (tab_addr),
		.wdata (ptime),
		.rdata (setup)
	);

	fcs_timing u_timing (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.issue  (issue),
		.setup  (setup),
		.s2_op  (s2_op),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			nm_q      <= fcs_pkg::NM_RESET;
		end else begin
			if (adv && s2_op) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (psel && penable && pwrite && pready && (paddr[2] == REG_NUM_MACHINES)) begin
				nm_q <= pwdata[fcs_pkg::NM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s2_op) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_q.machine, out_q.done};
	assign m_tlast  = out_q.last;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NUM_MACHINES) ? 32'(nm_q) : 32'd0;

endmodule
